/* rtl/sexpr_pkg.sv */
// Shared types, character codes and record helpers for the s-expression tokenizer.
// No dependencies; the decoder, result buffer, top level, checker and testbench import this package.
package sexpr_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		M_SKIP = 3'd0,
		M_NUM  = 3'd1,
		M_SYM  = 3'd2,
		M_STR  = 3'd3,
		M_ESC  = 3'd4,
		M_CMT  = 3'd5
	} lexer_mode_t;

	typedef enum logic [2:0] {
		K_BODY   = 3'd0,
		K_NUMBER = 3'd1,
		K_SYMBOL = 3'd2,
		K_STRING = 3'd3,
		K_QUOTE  = 3'd4,
		K_OPEN   = 3'd5,
		K_CLOSE  = 3'd6,
		K_EMPTY  = 3'd7
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t  kind;
		logic [7:0] value;
		logic       last;
	} rec_t;

	// Records produced by one byte: count 0..2, first record in rec0
	typedef struct packed {
		logic [1:0] cnt;
		rec_t       rec0;
		rec_t       rec1;
	} rec_pair_t;

	typedef struct packed {
		rec_pair_t   recs;
		lexer_mode_t mode_next;
	} dec_t;

	// Body records carry the byte; end marks carry zero
	function automatic rec_t mk_rec(rec_kind_t kind, logic [7:0] value);
		rec_t r;
		r.kind  = kind;
		r.value = (kind == K_BODY) ? value : 8'h00;
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/sexpr_byte_if.sv */
// Source byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
interface sexpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

/* rtl/sexpr_rec_if.sv */
// Token record channel: valid/ready handshake with kind, byte and run-end flag.
// Depends on nothing.
interface sexpr_rec_if;
	logic       valid;
	logic       ready;
	logic [2:0] record_kind;
	logic [7:0] byte_value;
	logic       last_of_run;

	modport source (output valid, output record_kind, output byte_value, output last_of_run,
		input ready);
	modport sink (input valid, input record_kind, input byte_value, input last_of_run,
		output ready);
endinterface

/* rtl/sexpr_decode.sv */
// Lexer decode: from the current mode and one byte, form up to two records and the next mode.
// Depends on sexpr_pkg.
module sexpr_decode
	import sexpr_pkg::*;
(
	input  lexer_mode_t mode,
	input  logic [7:0]  char_in,
	output dec_t        dec
);

	logic       has_tok;
	rec_t       tok_rec;
	rec_t       mark_rec;
	logic       is_digit;
	logic       is_space;
	logic [1:0] n;
	rec_t       r0;
	rec_t       r1;
	lexer_mode_t nxt;

	assign has_tok  = (mode == M_NUM) || (mode == M_SYM);
	assign tok_rec  = mk_rec((mode == M_NUM) ? K_NUMBER : K_SYMBOL, CH_NUL);
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_space = (char_in == CH_SPACE) || (char_in == CH_NL) || (char_in == CH_TAB);

	always_comb begin
		priority if (char_in == CH_SQUOTE) begin
			mark_rec = mk_rec(K_QUOTE, CH_NUL);
		end else if (char_in == CH_LPAREN) begin
			mark_rec = mk_rec(K_OPEN, CH_NUL);
		end else begin
			mark_rec = mk_rec(K_CLOSE, CH_NUL);
		end
	end

	always_comb begin
		n   = 2'd0;
		r0  = mk_rec(K_BODY, char_in);
		r1  = mk_rec(K_BODY, char_in);
		nxt = mode;
		unique case (mode)
			M_ESC: begin
				// Keep the backslash, then the escaped byte or the string end
				r0 = mk_rec(K_BODY, CH_BSLASH);
				n  = 2'd2;
				if (char_in == CH_NUL) begin
					r1  = mk_rec(K_STRING, CH_NUL);
					nxt = M_SKIP;
				end else begin
					nxt = M_STR;
				end
			end
			M_STR: begin
				if (char_in == CH_DQUOTE || char_in == CH_NUL) begin
					r0  = mk_rec(K_STRING, CH_NUL);
					n   = 2'd1;
					nxt = M_SKIP;
				end else if (char_in == CH_BSLASH) begin
					nxt = M_ESC;
				end else begin
					n = 2'd1;
				end
			end
			M_CMT: begin
				if (char_in == CH_NUL || char_in == CH_NL) begin
					r0  = mk_rec(K_EMPTY, CH_NUL);
					n   = 2'd1;
					nxt = M_SKIP;
				end
			end
			default: begin
				// Skip, number and symbol share one byte classifier
				priority if (is_digit) begin
					n = 2'd1;
					if (mode != M_NUM && mode != M_SYM) nxt = M_NUM;
				end else if (is_space) begin
					r0  = tok_rec;
					n   = has_tok ? 2'd1 : 2'd0;
					nxt = M_SKIP;
				end else if (char_in == CH_DQUOTE) begin
					if (mode == M_SYM) begin
						n = 2'd1;
					end else begin
						r0  = tok_rec;
						n   = has_tok ? 2'd1 : 2'd0;
						nxt = M_STR;
					end
				end else if (char_in == CH_SQUOTE || char_in == CH_LPAREN ||
						char_in == CH_RPAREN) begin
					if (has_tok) begin
						r0 = tok_rec;
						r1 = mark_rec;
						n  = 2'd2;
					end else begin
						r0 = mark_rec;
						n  = 2'd1;
					end
					nxt = M_SKIP;
				end else if (char_in == CH_NUL) begin
					r0  = has_tok ? tok_rec : mk_rec(K_EMPTY, CH_NUL);
					n   = 2'd1;
					nxt = M_SKIP;
				end else if (char_in == CH_SEMI) begin
					r0  = tok_rec;
					n   = has_tok ? 2'd1 : 2'd0;
					nxt = M_CMT;
				end else begin
					n   = 2'd1;
					nxt = M_SYM;
				end
			end
		endcase
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	assign dec.recs.cnt  = n;
	assign dec.recs.rec0 = r0;
	assign dec.recs.rec1 = r1;
	assign dec.mode_next = nxt;

endmodule

/* rtl/sexpr_rec_buf.sv */
// Two-entry result buffer: holds the records of one byte and drains them one beat at a time.
// Depends on sexpr_pkg and sexpr_rec_if.
module sexpr_rec_buf
	import sexpr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rec_pair_t pair,
	output logic      can_take,
	sexpr_rec_if.source rec_out
);

	logic [1:0] cnt_q;
	rec_t       slot0_q;
	rec_t       slot1_q;
	logic       pop;

	assign pop      = rec_out.valid && rec_out.ready;
	assign can_take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && pair.cnt != 2'd0) begin
			cnt_q <= pair.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && pair.cnt != 2'd0) begin
			slot0_q <= pair.rec0;
			slot1_q <= pair.rec1;
		end else if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
	end

	assign rec_out.valid       = (cnt_q != 2'd0);
	assign rec_out.record_kind = slot0_q.kind;
	assign rec_out.byte_value  = slot0_q.value;
	assign rec_out.last_of_run = slot0_q.last;

endmodule

/* rtl/sexpr_tokenizer_top.sv */
// Top level of the s-expression tokenizer: input register, lexer mode and result buffer.
// Depends on sexpr_pkg, sexpr_byte_if, sexpr_rec_if, sexpr_decode and sexpr_rec_buf.
//
// Source bytes enter one beat per cycle while the result buffer can take their records, and
// leave as token records: body records carrying text bytes, and one end-mark record per token
// giving its kind. A plain text stream moves at one byte per clock while the receiver is ready;
// a byte that yields two records (a token closed by a quote or bracket, or an escaped character)
// holds the input register longer, because the result buffer has a single output port and
// drains one record a beat. An accepted byte passes through the input register and then the
// result buffer on its way out. Byte 0 closes the input and sends the lexer back to skip mode,
// so the next stream starts clean.
module sexpr_tokenizer_top
	import sexpr_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	sexpr_byte_if.sink  byte_in,
	sexpr_rec_if.source rec_out
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	lexer_mode_t mode_q;
	dec_t        dec;
	logic        can_take;
	logic        advance;

	// Retire the held byte once its records fit into the buffer
	assign advance       = valid_s1 && ((dec.recs.cnt == 2'd0) || can_take);
	assign byte_in.ready = !valid_s1 || advance;

	// Input register: hold the byte until the decoder retires it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			char_s1 <= byte_in.char_in;
		end
	end

	// Lexer mode: advance only when the byte is retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
		end else if (advance) begin
			mode_q <= dec.mode_next;
		end
	end

	sexpr_decode u_decode (
		.mode    (mode_q),
		.char_in (char_s1),
		.dec     (dec)
	);

	sexpr_rec_buf u_rec_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.pair     (dec.recs),
		.can_take (can_take),
		.rec_out  (rec_out)
	);

endmodule

/* rtl/sexpr_tokenizer_checker.sv */
// Port-level checks for the s-expression tokenizer, bound to the top level.
// Depends on sexpr_pkg and sexpr_tokenizer_top.
module sexpr_tokenizer_checker
	import sexpr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_kind,
	input logic [7:0] out_value,
	input logic       out_last
);

	// A stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) &&
			$stable(out_last))
		else $error("stalled record changed");

	// End marks carry no text byte
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != K_BODY |-> out_value == 8'h00)
		else $error("end mark with non-zero byte");

	// The second record of a byte follows straight after the first
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a run of records");

	// String, quote, bracket and empty marks always close a run
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == K_STRING || out_kind == K_QUOTE || out_kind == K_OPEN ||
			out_kind == K_CLOSE || out_kind == K_EMPTY) |-> out_last)
		else $error("closing mark not last of run");

endmodule

bind sexpr_tokenizer_top sexpr_tokenizer_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rec_out.valid),
	.out_ready (rec_out.ready),
	.out_kind  (rec_out.record_kind),
	.out_value (rec_out.byte_value),
	.out_last  (rec_out.last_of_run)
);

/* tb/sexpr_tokenizer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for the s-expression tokenizer: random and directed byte streams, a scoreboard
// class that predicts every token record, and valid/ready pressure on both channels.
// Depends on sexpr_pkg, sexpr_byte_if, sexpr_rec_if and sexpr_tokenizer_top.
module sexpr_tokenizer_top_tb;
	import sexpr_pkg::*;

	// Tracks the lexer mode and holds the records each accepted byte should yield
	class token_scoreboard;
		lexer_mode_t mode;
		rec_t        awaited[$];
		rec_t        run[$];
		int          failures;

		function new();
			mode     = M_SKIP;
			failures = 0;
		endfunction

		function void emit(rec_kind_t kind, logic [7:0] value);
			rec_t r;
			r.kind  = kind;
			r.value = (kind == K_BODY) ? value : 8'h00;
			r.last  = 1'b0;
			run = {run, r};
		endfunction

		// End an open number or symbol with its mark
		function void close_token();
			if (mode == M_NUM)
				emit(K_NUMBER, 8'h00);
			else if (mode == M_SYM)
				emit(K_SYMBOL, 8'h00);
		endfunction

		function void note_byte(logic [7:0] c);
			bit digit;
			digit = (c >= CH_ZERO) && (c <= CH_NINE);
			run.delete();
			case (mode)
			M_ESC: begin
				emit(K_BODY, CH_BSLASH);
				if (c == CH_NUL) begin
					emit(K_STRING, 8'h00);
					mode = M_SKIP;
				end else begin
					emit(K_BODY, c);
					mode = M_STR;
				end
			end
			M_STR: begin
				if (c == CH_DQUOTE || c == CH_NUL) begin
					emit(K_STRING, 8'h00);
					mode = M_SKIP;
				end else if (c == CH_BSLASH) begin
					mode = M_ESC;
				end else begin
					emit(K_BODY, c);
				end
			end
			M_CMT: begin
				if (c == CH_NUL || c == CH_NL) begin
					emit(K_EMPTY, 8'h00);
					mode = M_SKIP;
				end
			end
			default: begin
				if (digit) begin
					if (mode != M_NUM && mode != M_SYM)
						mode = M_NUM;
					emit(K_BODY, c);
				end else if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
					close_token();
					mode = M_SKIP;
				end else if (c == CH_DQUOTE) begin
					if (mode == M_SYM) begin
						emit(K_BODY, c);
					end else begin
						close_token();
						mode = M_STR;
					end
				end else if (c == CH_SQUOTE || c == CH_LPAREN || c == CH_RPAREN) begin
					close_token();
					if (c == CH_SQUOTE)
						emit(K_QUOTE, 8'h00);
					else if (c == CH_LPAREN)
						emit(K_OPEN, 8'h00);
					else
						emit(K_CLOSE, 8'h00);
					mode = M_SKIP;
				end else if (c == CH_NUL) begin
					if (mode == M_NUM || mode == M_SYM)
						close_token();
					else
						emit(K_EMPTY, 8'h00);
					mode = M_SKIP;
				end else if (c == CH_SEMI) begin
					close_token();
					mode = M_CMT;
				end else begin
					emit(K_BODY, c);
					mode = M_SYM;
				end
			end
			endcase
			if (run.size() != 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				awaited = {awaited, run[i]};
		endfunction

		function string fmt(rec_t r);
			return $sformatf("kind %0d byte %02h last %0d", r.kind, r.value, r.last);
		endfunction

		function void complain(string detail);
			failures++;
			if (failures <= 10)
				$display("mismatch at %0t: %s", $realtime, detail);
		endfunction

		function void check_record(rec_t got);
			rec_t want;
			if (awaited.size() == 0) begin
				complain({"record with none awaited: ", fmt(got)});
				return;
			end
			want = awaited.pop_front();
			if (got.kind != want.kind || got.value != want.value || got.last != want.last)
				complain({"expected ", fmt(want), ", got ", fmt(got)});
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	localparam int DIRECTED_LEN = 33;
	localparam int RANDOM_LEN   = 1620;
	localparam int HOLD_CYCLES  = 300;

	logic clk;
	logic arst_n;

	sexpr_byte_if src_if();
	sexpr_rec_if  rec_if();

	sexpr_tokenizer_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (src_if),
		.rec_out (rec_if)
	);

	token_scoreboard sb = new();

	// Sender and receiver state; sink_style, hold_req and hold_left pass between the two
	int         sink_style = 0;
	bit         hold_req   = 1'b0;
	int         hold_left  = 0;
	int         sent       = 0;
	int         burst_left = 0;
	bit         gaps_on    = 1'b0;
	logic [7:0] text_q[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive one byte from the falling edge and hold it until the block takes the beat
	task automatic send_byte(input logic [7:0] c);
		@(negedge clk);
		src_if.valid   <= 1'b1;
		src_if.char_in <= c;
		do
			@(posedge clk);
		while (!src_if.ready);
		sb.note_byte(c);
		sent++;
	endtask

	task automatic idle_for(input int n);
		repeat (n) begin
			@(negedge clk);
			src_if.valid <= 1'b0;
		end
	endtask

	// Drop valid and hold off until every predicted record has come out
	task automatic wait_drained();
		@(negedge clk);
		src_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Bursts of random length; gaps between them only when idling is on and
	// the receiver is not in its long hold-off, so that the block backs up then
	task automatic send_text_byte(input logic [7:0] c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (gaps_on && !hold_req && hold_left == 0)
				idle_for($urandom_range(1, 8));
		end
		burst_left--;
		send_byte(c);
	endtask

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(0, 8))
		0: return CH_SPACE;
		1: return CH_NL;
		2: return CH_TAB;
		3: return CH_LPAREN;
		4: return CH_RPAREN;
		5: return CH_SQUOTE;
		6: return CH_DQUOTE;
		7: return CH_SEMI;
		default: return CH_NUL;
		endcase
	endfunction

	// Symbol text: anything but a delimiter; the first byte also avoids digits and quotes
	function automatic logic [7:0] symbol_byte(input bit first);
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_SPACE || b == CH_NL || b == CH_TAB || b == CH_LPAREN ||
			b == CH_RPAREN || b == CH_SQUOTE || b == CH_SEMI ||
			(first && (b == CH_DQUOTE || (b >= CH_ZERO && b <= CH_NINE))));
		return b;
	endfunction

	// Queue one byte at the tail of the pending text
	function automatic void append_text(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	// Append one lexically sound token with random content, or a little noise
	function automatic void add_sequence();
		int         pick;
		int         len;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			len = $urandom_range(1, 4);
			repeat (len) append_text(8'($urandom_range(0, 255)));
		end else if (pick < 30) begin
			len = $urandom_range(1, 6);
			repeat (len) append_text(8'($urandom_range(CH_ZERO, CH_NINE)));
			// now and then let a letter turn the number into a symbol
			if ($urandom_range(0, 4) == 0)
				append_text(symbol_byte(1'b1));
			append_text(pick_delim());
		end else if (pick < 50) begin
			append_text(symbol_byte(1'b1));
			len = $urandom_range(0, 7);
			repeat (len) append_text(symbol_byte(1'b0));
			append_text(pick_delim());
		end else if (pick < 70) begin
			append_text(CH_DQUOTE);
			len = $urandom_range(0, 8);
			repeat (len) begin
				if ($urandom_range(0, 4) == 0) begin
					append_text(CH_BSLASH);
					append_text(8'($urandom_range(1, 255)));
				end else begin
					do
						b = 8'($urandom_range(1, 255));
					while (b == CH_DQUOTE || b == CH_BSLASH);
					append_text(b);
				end
			end
			case ($urandom_range(0, 19))
			0: append_text(CH_NUL);
			1: begin
				append_text(CH_BSLASH);
				append_text(CH_NUL);
			end
			default: append_text(CH_DQUOTE);
			endcase
		end else if (pick < 80) begin
			append_text(CH_SEMI);
			len = $urandom_range(0, 6);
			repeat (len) begin
				do
					b = 8'($urandom_range(1, 255));
				while (b == CH_NL);
				append_text(b);
			end
			append_text(($urandom_range(0, 5) == 0) ? CH_NUL : CH_NL);
		end else if (pick < 92) begin
			case ($urandom_range(0, 2))
			0: append_text(CH_LPAREN);
			1: append_text(CH_RPAREN);
			default: append_text(CH_SQUOTE);
			endcase
		end else begin
			append_text(pick_delim());
		end
	endfunction

	// Receiver: a stall pattern per phase, and a long hold-off on request,
	// counted here so that the sender keeps pushing the whole time
	initial begin : receiver
		int beat_phase;
		beat_phase   = 0;
		rec_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			beat_phase++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rec_if.ready <= 1'b0;
			end else begin
				case (sink_style)
				0: rec_if.ready <= 1'b1;
				1: rec_if.ready <= ($urandom_range(0, 3) != 0);
				2: rec_if.ready <= 1'($urandom_range(0, 1));
				default: rec_if.ready <= ((beat_phase % 7) < 4);
				endcase
			end
		end
	end

	// Check every record beat against the oldest prediction
	always @(posedge clk) begin
		rec_t seen;
		if (arst_n && rec_if.valid && rec_if.ready) begin
			seen.kind  = rec_kind_t'(rec_if.record_kind);
			seen.value = rec_if.byte_value;
			seen.last  = rec_if.last_of_run;
			sb.check_record(seen);
		end
	end

	initial begin : stimulus
		logic [7:0] directed_text[DIRECTED_LEN];
		int         phase;

		// End of input on an empty stream, number ended by space, symbol holding a
		// quote, number turned symbol, number opening a string, escapes, brackets and
		// quote closing tokens, digits in a comment, top-bit bytes, the end byte in
		// escape, comment and number modes
		directed_text = '{CH_NUL, CH_ZERO, CH_NINE, CH_SPACE, "a", CH_DQUOTE, CH_TAB,
			"5", "x", CH_BSLASH, CH_NL, "7", CH_DQUOTE, CH_BSLASH, "n", CH_DQUOTE,
			CH_LPAREN, "4", CH_RPAREN, "q", CH_SQUOTE, CH_SEMI, "3", CH_NL,
			8'hFF, 8'h80, CH_SEMI, CH_NUL, CH_DQUOTE, CH_BSLASH, CH_NUL, "1", CH_NUL};

		src_if.valid   = 1'b0;
		src_if.char_in = 8'h00;
		arst_n         = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_text[i])
			send_byte(directed_text[i]);
		wait_drained();

		// Phase 0 runs flat out on both sides; later phases add idling, the long
		// receiver hold-off, and a full drain before the last one
		for (phase = 0; phase < 4; phase++) begin
			sink_style = phase;
			gaps_on    = (phase != 0);
			if (phase == 2)
				hold_req = 1'b1;
			if (phase == 3)
				wait_drained();
			while (sent < DIRECTED_LEN + (phase + 1) * (RANDOM_LEN / 4)) begin
				if (text_q.size() == 0)
					add_sequence();
				send_text_byte(text_q.pop_front());
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.complain($sformatf("%0d records never arrived", sb.pending()));

		if (sb.failures == 0)
			$display("sexpr_tokenizer_top_tb passed");
		else
			$display("sexpr_tokenizer_top_tb failed");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("sexpr_tokenizer_top_tb failed");
		$finish;
	end

endmodule
